// ===== sv/set_assoc_cache_tags_lru_unit_assert.svh =====
// Assertion macros used by the cache tag unit top level.
`ifndef SET_ASSOC_CACHE_TAGS_LRU_UNIT_ASSERT_SVH
`define SET_ASSOC_CACHE_TAGS_LRU_UNIT_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define SACTL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Same-cycle implication outside reset.
`define SACTL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== sv/sactl_pkg.sv =====
// Shared types and constants of the cache tag unit.
package sactl_pkg;

	localparam int ADDRESS_W = 32;

	typedef enum logic [0:0] {
		ACT_READ  = 1'b0,
		ACT_WRITE = 1'b1
	} action_t;

endpackage

// ===== sv/set_assoc_cache_tags_lru_unit.sv =====
// Top level of the set-associative cache tag array with true LRU replacement.
//
// Requests enter on start/action/address and are taken at any edge where start
// is high and busy is low; busy stays low, so one request can enter every cycle.
// Each request returns exactly one result: done pulses for one cycle with hit,
// which tells whether the tag sat in a valid way of its set before the access.
// done is high in the cycle after the one the request spends in stage 1,
// and one request per cycle is taken. The tag and LRU order of a set share
// one RAM row, read when the request is taken and written back from stage 1;
// a request to the set that is being written back picks up the new row from a
// bypass register. Reset clears all valid bits at once and needs no clearing
// pass; a set with no valid way reads its LRU order as way 0 oldest. The
// receiver cannot stall: each result is on the ports for its one strobe cycle.
`include "set_assoc_cache_tags_lru_unit_assert.svh"

module set_assoc_cache_tags_lru_unit #(
	parameter int SETS        = 64,
	parameter int WAYS        = 4,
	parameter int OFFSET_BITS = 4,
	parameter int ADDR_BITS   = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  sactl_pkg::action_t                 action,
	input  logic [sactl_pkg::ADDRESS_W-1:0]    address,
	output logic                               done,
	output logic                               hit
);

	import sactl_pkg::*;

	localparam int IDX_W   = $clog2(SETS);
	localparam int SW      = (IDX_W > 0) ? IDX_W : 1;
	localparam int WB      = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int TAG_RAW = ADDR_BITS - OFFSET_BITS - IDX_W;
	localparam int TAG_W   = (TAG_RAW > 0) ? TAG_RAW : 1;
	localparam int ROW_W   = WAYS * TAG_W + WAYS * WB;
	localparam logic [63:0] ADDR_MASK = (ADDR_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [63:0] IDX_MASK  = (64'd1 << IDX_W) - 64'd1;
	localparam logic [SW:0] SETS_C    = (SW + 1)'(SETS);

	// Request decode
	logic             accept;
	logic [63:0]      addr_ext;
	logic [SW:0]      idx_raw;
	logic [SW-1:0]    set_in;
	logic [TAG_W-1:0] tag_in;

	// Stage 1
	logic             v_s1;
	logic             fwd_s1;
	logic [SW-1:0]    set_s1;
	logic [TAG_W-1:0] tag_s1;
	action_t          action_s1;
	logic             wr_s1;

	logic [ROW_W-1:0] ram_row;
	logic [ROW_W-1:0] fwd_row_q;
	logic [ROW_W-1:0] cur_row;
	logic [ROW_W-1:0] new_row;
	logic [WAYS-1:0]  valid_q [SETS];
	logic [WAYS-1:0]  cur_valid;
	logic [WAYS-1:0]  new_valid;
	logic [WAYS-1:0]  hit_way;
	logic [TAG_W-1:0] tags [WAYS];
	logic [TAG_W-1:0] new_tags [WAYS];
	logic [WB-1:0]    order [WAYS];
	logic [WB-1:0]    new_order [WAYS];
	logic [WB-1:0]    hit_pos;
	logic [WB-1:0]    free_pos;
	logic [WB-1:0]    pick_pos;
	logic [WB-1:0]    use_way;
	logic             found;
	logic             free_found;

	// Result register
	logic             done_q;
	logic             hit_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_comb begin
		addr_ext = 64'(address) & ADDR_MASK;
		idx_raw  = (SW + 1)'((addr_ext >> OFFSET_BITS) & IDX_MASK);
		// wrap an index field beyond the last set
		if (idx_raw >= SETS_C) begin
			idx_raw = idx_raw - SETS_C;
		end
		set_in = idx_raw[SW-1:0];
		tag_in = TAG_W'(addr_ext >> (OFFSET_BITS + IDX_W));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1    <= set_in;
			tag_s1    <= tag_in;
			action_s1 <= action;
			fwd_s1    <= v_s1 && (set_s1 == set_in);
		end
		if (v_s1) begin
			fwd_row_q <= new_row;
		end
	end

	assign wr_s1 = v_s1 && (action_s1 == ACT_WRITE);

	sactl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(SETS)
	) u_row_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(set_s1),
		.wdata(new_row),
		.re   (accept),
		.raddr(set_in),
		.rdata(ram_row)
	);

	always_comb begin
		cur_row   = fwd_s1 ? fwd_row_q : ram_row;
		cur_valid = valid_q[set_s1];
		for (int w = 0; w < WAYS; w++) begin
			tags[w]    = cur_row[w*TAG_W +: TAG_W];
			hit_way[w] = cur_valid[w] && (tags[w] == tag_s1);
		end
		// an untouched set has identity order
		for (int p = 0; p < WAYS; p++) begin
			order[p] = (cur_valid == '0) ? WB'(p) : cur_row[WAYS*TAG_W + p*WB +: WB];
		end
		hit_pos    = '0;
		free_pos   = '0;
		found      = 1'b0;
		free_found = 1'b0;
		// scan from newest down so the oldest match wins
		for (int p = WAYS - 1; p >= 0; p--) begin
			if (hit_way[order[p]]) begin
				hit_pos = WB'(p);
				found   = 1'b1;
			end
			if (!cur_valid[order[p]]) begin
				free_pos   = WB'(p);
				free_found = 1'b1;
			end
		end
		priority if (found) begin
			pick_pos = hit_pos;
		end else if (free_found) begin
			pick_pos = free_pos;
		end else begin
			pick_pos = '0;
		end
		use_way = order[pick_pos];

		for (int i = 0; i < WAYS - 1; i++) begin
			new_order[i] = (WB'(i) < pick_pos) ? order[i] : order[i+1];
		end
		new_order[WAYS-1] = use_way;

		for (int w = 0; w < WAYS; w++) begin
			new_tags[w] = (WB'(w) == use_way) ? tag_s1 : tags[w];
		end
		new_valid = cur_valid;
		new_valid[use_way] = 1'b1;

		for (int w = 0; w < WAYS; w++) begin
			new_row[w*TAG_W +: TAG_W]          = new_tags[w];
			new_row[WAYS*TAG_W + w*WB +: WB]   = new_order[w];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SETS; s++) begin
				valid_q[s] <= '0;
			end
		end else if (v_s1) begin
			valid_q[set_s1] <= new_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			hit_q <= found;
		end
	end

	assign done = done_q;
	assign hit  = hit_q;

	`SACTL_ASSERT(a_result_follows, v_s1 |=> done_q, "request in stage 1 gave no result")
	`SACTL_ASSERT_IMP(a_hit_unique, v_s1, $onehot0(hit_way), "tag present in two ways of a set")
	`SACTL_ASSERT_IMP(a_fwd_set_live, v_s1 && fwd_s1, |valid_q[set_s1], "bypassed set empty")
	`SACTL_ASSERT(a_write_fills, wr_s1 |=> valid_q[$past(set_s1)][$past(use_way)], "write way invalid")

endmodule

// ===== sv/sactl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sactl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
